FILE: src/futd_pkg.sv
package futd_pkg;

	// Width of the record counter; the glyph number port shows its low bits.
	localparam int GLYPH_COUNT_BITS = 16;

	localparam int CP_W    = 21;
	localparam int GLYPH_W = 16;
	localparam int BYTE_W  = 8;

	localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

	localparam logic [GLYPH_COUNT_BITS-1:0] COUNT_MAX = {GLYPH_COUNT_BITS{1'b1}};

	localparam logic [BYTE_W-1:0] BYTE_RECORD_END = 8'hFF;

	localparam logic [1:0] PENDING_NONE = 2'd0;
	localparam logic [1:0] PENDING_ONE  = 2'd1;
	localparam logic [1:0] PENDING_TWO  = 2'd2;
	localparam logic [1:0] PENDING_THREE = 2'd3;

endpackage

FILE: src/font_unicode_table_decoder_top.sv
// Font unicode table decoder.
// The input channel (in_valid/in_ready) moves one table byte per transfer,
// with end_of_table marking the last byte of a table. Bytes are decoded as
// UTF-8; every complete code point below 0x110000 gives one transfer on the
// output channel (out_valid/out_ready) carrying the code point and the
// current glyph number. The byte FF, or a four-byte value of 0x110000, closes
// a record and advances the glyph number, which saturates at its top value.
// Bytes that close a record, start or continue a sequence, or are invalid
// give no output transfer.
// A byte is held in the input register and its result in the result register;
// the result can transfer once it is in the result register. Throughput is one
// byte per cycle while the receiver does not stall: the decoder state lives in a
// few small registers updated once per byte.
// When the receiver stalls, the result register holds its item and the
// input register holds the next byte; in_ready drops once both are full.
// Reset clears the open sequence, the glyph counter and both valid flags.
// After a byte with end_of_table set, the open sequence and the glyph
// counter are cleared before the next byte.
module font_unicode_table_decoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [futd_pkg::BYTE_W-1:0]  table_byte,
	input  logic                         end_of_table,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [futd_pkg::CP_W-1:0]    mapped_code_point,
	output logic [futd_pkg::GLYPH_W-1:0] glyph_number
);
	import futd_pkg::*;

	logic                        valid_s1;
	logic [BYTE_W-1:0]           byte_s1;
	logic                        end_s1;

	logic [1:0]                  bytes_pending_q;
	logic [CP_W-1:0]             partial_q;
	logic                        four_byte_q;
	logic [GLYPH_COUNT_BITS-1:0] record_counter_q;

	logic                        out_valid_q;
	logic [CP_W-1:0]             code_point_q;
	logic [GLYPH_W-1:0]          glyph_q;

	logic                        advance_s1;
	logic                        is_cont;
	logic [CP_W-1:0]             shifted_value;
	logic [1:0]                  pending_dec;
	logic [1:0]                  pending_n;
	logic [CP_W-1:0]             partial_n;
	logic                        four_n;
	logic                        end_record;
	logic                        emit;
	logic [CP_W-1:0]             emit_value;

	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= table_byte;
			end_s1  <= end_of_table;
		end
	end

	assign is_cont       = (byte_s1[7:6] == 2'b10);
	assign shifted_value = {partial_q[CP_W-7:0], byte_s1[5:0]};
	assign pending_dec   = bytes_pending_q - 2'd1;

	always_comb begin
		pending_n  = bytes_pending_q;
		partial_n  = partial_q;
		four_n     = four_byte_q;
		end_record = 1'b0;
		emit       = 1'b0;
		emit_value = shifted_value;

		if (bytes_pending_q != PENDING_NONE && is_cont) begin
			partial_n = shifted_value;
			pending_n = pending_dec;
			if (pending_dec == PENDING_NONE) begin
				if (four_byte_q) begin
					four_n = 1'b0;
					if (shifted_value == CP_LIMIT) begin
						end_record = 1'b1;
					end else if (shifted_value <= CP_MAX) begin
						emit = 1'b1;
					end
				end else begin
					emit = 1'b1;
				end
			end
		end else begin
			// Any open sequence is dropped; the byte is taken as a new lead.
			pending_n = PENDING_NONE;
			partial_n = '0;
			four_n    = 1'b0;
			priority if (byte_s1[7:3] == 5'b11111) begin
				end_record = (byte_s1 == BYTE_RECORD_END);
			end else if (!byte_s1[7]) begin
				emit       = 1'b1;
				emit_value = CP_W'(byte_s1);
			end else if (is_cont) begin
				// A stray continuation byte is ignored.
			end else if (!byte_s1[5]) begin
				partial_n = CP_W'(byte_s1[4:0]);
				pending_n = PENDING_ONE;
			end else if (!byte_s1[4]) begin
				partial_n = CP_W'(byte_s1[3:0]);
				pending_n = PENDING_TWO;
			end else begin
				partial_n = CP_W'(byte_s1[2:0]);
				pending_n = PENDING_THREE;
				four_n    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_pending_q  <= PENDING_NONE;
			partial_q        <= '0;
			four_byte_q      <= 1'b0;
			record_counter_q <= '0;
		end else if (advance_s1) begin
			if (end_s1) begin
				bytes_pending_q  <= PENDING_NONE;
				partial_q        <= '0;
				four_byte_q      <= 1'b0;
				record_counter_q <= '0;
			end else begin
				bytes_pending_q <= pending_n;
				partial_q       <= partial_n;
				four_byte_q     <= four_n;
				if (end_record && record_counter_q != COUNT_MAX) begin
					record_counter_q <= record_counter_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			code_point_q <= emit_value;
			glyph_q      <= GLYPH_W'(record_counter_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign mapped_code_point = code_point_q;
	assign glyph_number      = glyph_q;

	a_four_byte_open: assert property (@(posedge clk) disable iff (!arst_n)
		four_byte_q |-> bytes_pending_q != PENDING_NONE)
		else $error("four-byte flag set with no sequence open");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && end_s1 |=> record_counter_q == '0 && bytes_pending_q == PENDING_NONE)
		else $error("end of table did not clear the decoder state");

	a_counter_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && !end_s1 |=> record_counter_q >= $past(record_counter_q))
		else $error("record counter decreased without end of table");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance_s1)
		else $error("input stage advanced over a stalled result");

	a_cp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> code_point_q <= CP_MAX)
		else $error("code point out of range on output");

endmodule

FILE: tb/tb_font_unicode_table_decoder_top.sv
module tb_font_unicode_table_decoder_top;
	import futd_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0]    cp;
		logic [GLYPH_W-1:0] glyph;
	} mapping_t;

	typedef enum {ROW_PREDICT, ROW_NONE, ROW_VALUE} row_kind_t;

	typedef struct {
		logic [BYTE_W-1:0]  b;
		logic               eot;
		row_kind_t          kind;
		logic [CP_W-1:0]    cp;
		logic [GLYPH_W-1:0] glyph;
	} table_row_t;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_BYTES  = 280;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_ROWS     = 27;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [BYTE_W-1:0]   table_byte;
	logic                end_of_table;
	logic                out_valid;
	logic                out_ready;
	logic [CP_W-1:0]     mapped_code_point;
	logic [GLYPH_W-1:0]  glyph_number;

	// Decoder state as the predictor sees it.
	logic [1:0]                  dec_pending;
	logic [CP_W-1:0]             dec_partial;
	logic                        dec_four;
	logic [GLYPH_COUNT_BITS-1:0] dec_records;

	mapping_t   expected_maps[$];
	mapping_t   want;
	table_row_t directed_rows[NUM_ROWS];
	int         mismatches;
	int         cycles;
	int         bytes_sent;
	int         tx_idle_pct;
	int         rx_idle_pct;

	font_unicode_table_decoder_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.table_byte       (table_byte),
		.end_of_table     (end_of_table),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mapped_code_point(mapped_code_point),
		.glyph_number     (glyph_number)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic bump_records();
		if (dec_records != COUNT_MAX) begin
			dec_records = dec_records + 1'b1;
		end
	endtask

	// Advances the predicted decoder by one byte and tells whether a mapping
	// write comes out of it.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eot,
			output logic hit, output mapping_t map);
		logic cont;
		logic taken;
		cont  = (b[7:6] == 2'b10);
		taken = 1'b0;
		hit   = 1'b0;
		map   = '0;
		if (dec_pending != PENDING_NONE) begin
			if (cont) begin
				taken       = 1'b1;
				dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
				dec_pending = dec_pending - 1'b1;
				if (dec_pending == PENDING_NONE) begin
					if (dec_four) begin
						dec_four = 1'b0;
						if (dec_partial == CP_LIMIT) begin
							bump_records();
						end else if (dec_partial <= CP_MAX) begin
							hit = 1'b1;
						end
					end else begin
						hit = 1'b1;
					end
					map.cp = dec_partial;
				end
			end else begin
				dec_pending = PENDING_NONE;
				dec_partial = '0;
				dec_four    = 1'b0;
			end
		end
		if (!taken) begin
			if (b[7:3] == 5'b11111) begin
				if (b == BYTE_RECORD_END) begin
					bump_records();
				end
			end else if (!b[7]) begin
				hit    = 1'b1;
				map.cp = CP_W'(b);
			end else if (!cont) begin
				if (!b[5]) begin
					dec_partial = CP_W'(b[4:0]);
					dec_pending = PENDING_ONE;
				end else if (!b[4]) begin
					dec_partial = CP_W'(b[3:0]);
					dec_pending = PENDING_TWO;
				end else begin
					dec_partial = CP_W'(b[2:0]);
					dec_pending = PENDING_THREE;
					dec_four    = 1'b1;
				end
			end
		end
		map.glyph = GLYPH_W'(dec_records);
		if (eot) begin
			dec_pending = PENDING_NONE;
			dec_partial = '0;
			dec_four    = 1'b0;
			dec_records = '0;
		end
	endtask

	// Offers one byte, waits for its transfer and runs the predictor on it.
	// Valid stays high after a transfer until the next byte or an idle cycle.
	task automatic transfer_byte(input logic [BYTE_W-1:0] b, input logic eot,
			output logic hit, output mapping_t map);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		table_byte   <= b;
		end_of_table <= eot;
		do begin
			@(posedge clk);
		end while (!in_ready);
		bytes_sent++;
		decode_byte(b, eot, hit, map);
	endtask

	task automatic send_predicted(input logic [BYTE_W-1:0] b, input logic eot);
		logic     hit;
		mapping_t map;
		transfer_byte(b, eot, hit, map);
		if (hit) begin
			expected_maps.push_back(map);
		end
	endtask

	// Mostly well-formed UTF-8 with random content, plus record ends,
	// broken sequences and raw noise.
	task automatic send_utf8_unit();
		logic [BYTE_W-1:0] seq[$];
		logic [BYTE_W-1:0] lead;
		int                kind;
		int                keep;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			seq.push_back(8'($urandom_range(0, 127)));
		end else if (kind < 35) begin
			seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
			seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
		end else if (kind < 55) begin
			seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
			repeat (2) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
		end else if (kind < 75) begin
			if ($urandom_range(0, 7) == 0) begin
				seq = '{8'hF4, 8'h90, 8'h80, 8'h80};
			end else begin
				seq.push_back(8'hF0 | 8'($urandom_range(0,
					($urandom_range(0, 3) == 0) ? 7 : 4)));
				repeat (3) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		end else if (kind < 83) begin
			seq.push_back(BYTE_RECORD_END);
		end else if (kind < 90) begin
			// A sequence cut short by a byte that is not a continuation.
			lead = 8'hC0 | 8'($urandom_range(0, 55));
			keep = $urandom_range(0, (lead >= 8'hF0) ? 2 : (lead >= 8'hE0) ? 1 : 0);
			seq.push_back(lead);
			repeat (keep) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
			if ($urandom_range(0, 1) == 0) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else begin
				seq.push_back(8'hC0 | 8'($urandom_range(0, 63)));
			end
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end
		foreach (seq[i]) begin
			send_predicted(seq[i], $urandom_range(0, 99) == 0);
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_maps.size() == 0) begin
				report_mismatch($sformatf("unexpected result cp=%h glyph=%h",
					mapped_code_point, glyph_number));
			end else begin
				want = expected_maps.pop_front();
				if (mapped_code_point !== want.cp) begin
					report_mismatch($sformatf("code point %h, expected %h",
						mapped_code_point, want.cp));
				end
				if (glyph_number !== want.glyph) begin
					report_mismatch($sformatf("glyph %h, expected %h (cp %h)",
						glyph_number, want.glyph, want.cp));
				end
			end
		end
	end

	initial begin
		logic     hit;
		mapping_t map;
		mapping_t row_map;
		int       start_count;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		table_byte   = '0;
		end_of_table = 1'b0;
		mismatches   = 0;
		bytes_sent   = 0;
		tx_idle_pct  = 8;
		rx_idle_pct  = 47;
		dec_pending  = PENDING_NONE;
		dec_partial  = '0;
		dec_four     = 1'b0;
		dec_records  = '0;

		directed_rows = '{
			'{8'h00, 1'b0, ROW_VALUE,   21'h000000, 16'd0},
			'{8'h7F, 1'b0, ROW_VALUE,   21'h00007F, 16'd0},
			'{8'h80, 1'b0, ROW_NONE,    21'h0, 16'd0},     // stray continuation
			'{8'hF8, 1'b0, ROW_NONE,    21'h0, 16'd0},     // invalid leads
			'{8'hFE, 1'b0, ROW_NONE,    21'h0, 16'd0},
			'{8'hFF, 1'b0, ROW_NONE,    21'h0, 16'd0},     // record end
			'{8'hC2, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hA9, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hE2, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'h82, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hAC, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hF4, 1'b0, ROW_PREDICT, 21'h0, 16'd0},     // largest code point
			'{8'h8F, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hBF, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hBF, 1'b0, ROW_VALUE,   21'h10FFFF, 16'd1},
			'{8'hF4, 1'b0, ROW_PREDICT, 21'h0, 16'd0},     // value that ends a record
			'{8'h90, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'h80, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'h80, 1'b0, ROW_NONE,    21'h0, 16'd0},
			'{8'hF7, 1'b0, ROW_PREDICT, 21'h0, 16'd0},     // out of range value
			'{8'hBF, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hBF, 1'b0, ROW_PREDICT, 21'h0, 16'd0},
			'{8'hBF, 1'b0, ROW_NONE,    21'h0, 16'd0},
			'{8'hE2, 1'b0, ROW_PREDICT, 21'h0, 16'd0},     // broken sequence
			'{8'h41, 1'b0, ROW_VALUE,   21'h000041, 16'd2},
			'{8'hC3, 1'b1, ROW_NONE,    21'h0, 16'd0},     // truncated at table end
			'{8'h5A, 1'b0, ROW_VALUE,   21'h00005A, 16'd0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			transfer_byte(directed_rows[i].b, directed_rows[i].eot, hit, map);
			case (directed_rows[i].kind)
				ROW_PREDICT: begin
					if (hit) begin
						expected_maps.push_back(map);
					end
				end
				ROW_NONE: begin
					if (hit) begin
						report_mismatch($sformatf("row %0d: predictor gives a result", i));
					end
				end
				default: begin
					row_map.cp    = directed_rows[i].cp;
					row_map.glyph = directed_rows[i].glyph;
					expected_maps.push_back(row_map);
					if (!hit || map != row_map) begin
						report_mismatch($sformatf("row %0d: predictor disagrees", i));
					end
				end
			endcase
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 8;
					rx_idle_pct = 47;
				end
				1: begin
					tx_idle_pct = 47;
					rx_idle_pct = 8;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			start_count = bytes_sent;
			while (bytes_sent - start_count < PHASE_BYTES) begin
				send_utf8_unit();
			end
		end

		// Close out with a table end and a byte after it.
		repeat (20) send_utf8_unit();
		send_predicted(8'h41, 1'b1);
		send_predicted(8'h42, 1'b0);
		in_valid <= 1'b0;

		while (expected_maps.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: font_unicode_table_decoder_top.f
src/futd_pkg.sv
src/font_unicode_table_decoder_top.sv
tb/tb_font_unicode_table_decoder_top.sv
